// File: rtl/bpw_pkg.sv
// Shared widths, reset values, register indexes, input action codes and step-direction codes for the point walker.
package bpw_pkg;

  // Coordinate and error widths
  localparam int unsigned X_W   = 9;
  localparam int unsigned Y_W   = 8;
  localparam int unsigned ERR_W = 10;

  // Packed stream widths, padded to whole bytes
  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 24;

  // Configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned CFG_W  = 32;

  // Register indexes (byte address is 4 * index)
  localparam logic REG_START_X = 1'b0;
  localparam logic REG_START_Y = 1'b1;

  // Reset values of the start position
  localparam logic [X_W-1:0] START_X_RST = 9'h094;
  localparam logic [Y_W-1:0] START_Y_RST = 8'h50;

  // Input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Step direction along one axis
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd3
  } dir_t;

endpackage

// File: rtl/bresenham_point_walker.sv
// Bresenham point walker: start/step stream in, one position result per transaction out.
//
// Usage:
//   Slave stream (s_*) carries one command per transaction. s_tuser is the action:
//   0 starts a new walk from the configured start position toward the target in
//   s_tdata, 1 takes one pixel step along the current line.
//   Master stream (m_*) returns one result per command: position in m_tdata and
//   the done flag in m_tuser. Done is set once the major coordinate hits the
//   target; later steps hold the position with done kept set.
//   The APB port sets start_x (address 0) and start_y (address 4); write it only
//   while no command is in flight.
// Timing:
//   m_tvalid and the result are registered at the accepting edge. The walker state
//   updates in the same cycle as the command is accepted, so a new command can be
//   taken every cycle: one command per cycle sustained while m_tready stays high.
//   While the receiver stalls, the result register holds and s_tready drops
//   until the result is taken; s_tready is high again in the taking cycle.
// Reset:
//   Synchronous active-high rst clears the walk state to zero (x major, no
//   movement), reloads start 148,80 and empties the result register.
module bresenham_point_walker (
  input  logic                           clk,
  input  logic                           rst,
  // Command stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bpw_pkg::S_DATA_W-1:0]   s_tdata,   // [8:0] target_x, [16:9] target_y
  input  logic                           s_tuser,   // [0] action
  // Result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bpw_pkg::M_DATA_W-1:0]   m_tdata,   // [8:0] pos_x, [16:9] pos_y
  output logic                           m_tuser,   // [0] done_res
  // Configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpw_pkg::ADDR_W-1:0]     paddr,
  input  logic [bpw_pkg::CFG_W-1:0]      pwdata,
  output logic [bpw_pkg::CFG_W-1:0]      prdata,
  output logic                           pready
);
  import bpw_pkg::*;

  // Configuration registers
  logic [X_W-1:0] start_x;
  logic [Y_W-1:0] start_y;

  // Walk state
  logic [X_W-1:0]   cur_x, cur_x_next;
  logic [Y_W-1:0]   cur_y, cur_y_next;
  logic [X_W-1:0]   goal_x, goal_x_next;
  logic [Y_W-1:0]   goal_y, goal_y_next;
  dir_t             dir_x, dir_x_next;
  dir_t             dir_y, dir_y_next;
  logic [X_W-1:0]   delta_x, delta_x_next;
  logic [Y_W-1:0]   delta_y, delta_y_next;
  logic [ERR_W-1:0] error_acc, error_acc_next;
  logic             y_major, y_major_next;
  logic             reached, reached_next;

  // Start-item arithmetic
  logic [X_W-1:0] tgt_x;
  logic [Y_W-1:0] tgt_y;

  // Step-item arithmetic
  logic [ERR_W-1:0] major_d, minor_d;
  logic             minor_go;
  logic [ERR_W:0]   err_sum;
  logic [X_W-1:0]   step_x;
  logic [Y_W-1:0]   step_y;

  logic accept;
  logic cfg_wr;

  assign accept   = s_tvalid & s_tready;
  assign s_tready = ~m_tvalid | m_tready;

  assign tgt_x = s_tdata[X_W-1:0];
  assign tgt_y = s_tdata[X_W+Y_W-1:X_W];

  // APB access: always ready, reads return the register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    unique case (paddr[2])
      REG_START_X: prdata = {{(CFG_W-X_W){1'b0}}, start_x};
      REG_START_Y: prdata = {{(CFG_W-Y_W){1'b0}}, start_y};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= START_X_RST;
      start_y <= START_Y_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_START_X) begin
        start_x <= pwdata[X_W-1:0];
      end else begin
        start_y <= pwdata[Y_W-1:0];
      end
    end
  end

  // One position step for each axis along its direction
  always_comb begin
    unique case (dir_x)
      DIR_POS: step_x = cur_x + X_W'(1);
      DIR_NEG: step_x = cur_x - X_W'(1);
      default: step_x = cur_x;
    endcase
    unique case (dir_y)
      DIR_POS: step_y = cur_y + Y_W'(1);
      DIR_NEG: step_y = cur_y - Y_W'(1);
      default: step_y = cur_y;
    endcase
  end

  // Error update: minor axis moves when error is below the minor delta
  always_comb begin
    if (y_major) begin
      major_d = {{(ERR_W-Y_W){1'b0}}, delta_y};
      minor_d = {{(ERR_W-X_W){1'b0}}, delta_x};
    end else begin
      major_d = {{(ERR_W-X_W){1'b0}}, delta_x};
      minor_d = {{(ERR_W-Y_W){1'b0}}, delta_y};
    end
    minor_go = error_acc < minor_d;
    err_sum  = {1'b0, error_acc} + (minor_go ? {1'b0, major_d} : '0) - {1'b0, minor_d};
  end

  // Next walk state
  always_comb begin
    cur_x_next     = cur_x;
    cur_y_next     = cur_y;
    goal_x_next    = goal_x;
    goal_y_next    = goal_y;
    dir_x_next     = dir_x;
    dir_y_next     = dir_y;
    delta_x_next   = delta_x;
    delta_y_next   = delta_y;
    error_acc_next = error_acc;
    y_major_next   = y_major;
    reached_next   = reached;

    if (s_tuser == ACT_START) begin
      // Load a new line from the start position
      cur_x_next  = start_x;
      cur_y_next  = start_y;
      goal_x_next = tgt_x;
      goal_y_next = tgt_y;
      if (tgt_x > start_x) begin
        dir_x_next   = DIR_POS;
        delta_x_next = tgt_x - start_x;
      end else if (tgt_x < start_x) begin
        dir_x_next   = DIR_NEG;
        delta_x_next = start_x - tgt_x;
      end else begin
        dir_x_next   = DIR_NONE;
        delta_x_next = '0;
      end
      if (tgt_y > start_y) begin
        dir_y_next   = DIR_POS;
        delta_y_next = tgt_y - start_y;
      end else if (tgt_y < start_y) begin
        dir_y_next   = DIR_NEG;
        delta_y_next = start_y - tgt_y;
      end else begin
        dir_y_next   = DIR_NONE;
        delta_y_next = '0;
      end
      // y is major only when strictly longer
      if ({1'b0, delta_y_next} > delta_x_next) begin
        y_major_next   = 1'b1;
        error_acc_next = {{(ERR_W-Y_W+1){1'b0}}, delta_y_next[Y_W-1:1]};
      end else begin
        y_major_next   = 1'b0;
        error_acc_next = {{(ERR_W-X_W+1){1'b0}}, delta_x_next[X_W-1:1]};
      end
      reached_next = 1'b0;
    end else if (!reached) begin
      // One pixel along the major axis, maybe one along the minor
      error_acc_next = err_sum[ERR_W-1:0];
      if (y_major) begin
        cur_y_next   = step_y;
        if (minor_go) begin
          cur_x_next = step_x;
        end
        reached_next = (step_y == goal_y);
      end else begin
        cur_x_next   = step_x;
        if (minor_go) begin
          cur_y_next = step_y;
        end
        reached_next = (step_x == goal_x);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x     <= '0;
      cur_y     <= '0;
      goal_x    <= '0;
      goal_y    <= '0;
      dir_x     <= DIR_NONE;
      dir_y     <= DIR_NONE;
      delta_x   <= '0;
      delta_y   <= '0;
      error_acc <= '0;
      y_major   <= 1'b0;
      reached   <= 1'b0;
    end else if (accept) begin
      cur_x     <= cur_x_next;
      cur_y     <= cur_y_next;
      goal_x    <= goal_x_next;
      goal_y    <= goal_y_next;
      dir_x     <= dir_x_next;
      dir_y     <= dir_y_next;
      delta_x   <= delta_x_next;
      delta_y   <= delta_y_next;
      error_acc <= error_acc_next;
      y_major   <= y_major_next;
      reached   <= reached_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {{(M_DATA_W-X_W-Y_W){1'b0}}, cur_y_next, cur_x_next};
      m_tuser <= reached_next;
    end
  end

endmodule
